// ----- design/bls_pkg.sv -----
`timescale 1ns / 1ps

package bls_pkg;

  // Default stack depth
  localparam int DEPTH_DEFAULT = 8;

  // Field widths fixed by the command and result formats
  localparam int CMD_W    = 3;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_DISPLAY = 3'd2,
    CMD_PEEK    = 3'd3,
    CMD_CHANGE  = 3'd4
  } cmd_e_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_BADPOS   = 2'd3
  } status_e_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_PUSH   = 3'd1,
    OP_POP    = 3'd2,
    OP_ROTATE = 3'd3,
    OP_WRITE  = 3'd4
  } cell_op_t;

  // Control bundle from the sequencer to the chain
  typedef struct packed {
    cell_op_t                 op;
    logic signed [WORD_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- design/bls_if.sv -----
`timescale 1ns / 1ps

// Command channel
interface bls_in_if import bls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [WORD_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink (input valid, cmd, value, position, output ready);
endinterface

// Result channel
interface bls_out_if import bls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] data;
  logic                     last;

  modport source (output valid, status, data, last, input ready);
  modport sink (input valid, status, data, last, output ready);
endinterface

// ----- design/bounded_lifo_stack.sv -----
`timescale 1ns / 1ps

// Bounded LIFO stack of signed 32-bit words.
// in_ch carries one command per request: push, pop, display, peek or change,
// with a value and a position counted from the top (1 is the top).
// out_ch returns results with a status, a data word and a last flag.
// Push, pop, peek and change each produce one result in the cycle after
// acceptance; a new command can follow every cycle while out_ch is ready.
// Display emits the stored words top to bottom, one per cycle while out_ch
// is ready, by rotating the cell row once per word; it takes no command in
// the sweep, and the row is back in order when the bottom word goes out.
// Peek reads the addressed cell through an OR bus over all cells.
// Unknown command codes are accepted and dropped with no result.
// A single output register holds each result; a new command is taken while
// that result is being taken. When out_ch stalls, the register holds and
// in_ch.ready drops until the slot frees.
// Reset (rst_n low, synchronous) empties the stack and clears the output valid.
// Stored words are not cleared; only pushed words are ever read.
module bounded_lifo_stack import bls_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic clk,
  input logic rst_n,
  bls_in_if.sink    in_ch,
  bls_out_if.source out_ch
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DISP = 2'b10
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            disp_r, disp_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_e_t                out_status_r, out_status_nxt;
  logic signed [WORD_W-1:0] out_data_r, out_data_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     slot_free;
  logic                     in_ready;
  logic                     in_fire;
  logic                     out_load;
  logic                     empty;
  logic                     full;
  logic                     bad_pos;
  logic [PW-1:0]            pos_ext;
  logic [PW-1:0]            cnt_ext;
  logic [IW-1:0]            sel_idx;
  logic [IW-1:0]            last_idx;
  cell_ctrl_t               ctrl;
  logic signed [WORD_W-1:0] top_data;
  logic signed [WORD_W-1:0] peek_data;

  // Handshake
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ready    = (state_r == S_IDLE) && slot_free;
  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  // Stack condition and position checks
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(DEPTH));
  assign pos_ext  = PW'(in_ch.position);
  assign cnt_ext  = PW'(cnt_r);
  assign bad_pos  = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign sel_idx  = IW'(pos_ext - PW'(1));
  assign last_idx = IW'(cnt_r - CW'(1));

  // Sequence commands and the display sweep
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    disp_nxt       = disp_r;
    ctrl.op        = OP_HOLD;
    ctrl.value     = in_ch.value;
    out_load       = 1'b0;
    out_status_nxt = STAT_OK;
    out_data_nxt   = '0;
    out_last_nxt   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (cmd_e_t'(in_ch.cmd))
            CMD_PUSH: begin
              out_load = 1'b1;
              if (full) begin
                out_status_nxt = STAT_OVERFLOW;
              end else begin
                ctrl.op      = OP_PUSH;
                cnt_nxt      = cnt_r + CW'(1);
                out_data_nxt = in_ch.value;
              end
            end
            CMD_POP: begin
              out_load = 1'b1;
              if (empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                ctrl.op      = OP_POP;
                cnt_nxt      = cnt_r - CW'(1);
                out_data_nxt = top_data;
              end
            end
            CMD_DISPLAY: begin
              if (empty) begin
                out_load       = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else begin
                state_nxt = S_DISP;
                disp_nxt  = cnt_r;
              end
            end
            CMD_PEEK: begin
              out_load = 1'b1;
              if (empty) begin
                out_status_nxt = STAT_EMPTY;
              end else if (bad_pos) begin
                out_status_nxt = STAT_BADPOS;
              end else begin
                out_data_nxt = peek_data;
              end
            end
            CMD_CHANGE: begin
              out_load = 1'b1;
              if (empty) begin
                out_status_nxt = STAT_EMPTY;
              end else if (bad_pos) begin
                out_status_nxt = STAT_BADPOS;
              end else begin
                ctrl.op = OP_WRITE;
              end
            end
            default: begin
              // drop unknown command
            end
          endcase
        end
      end
      S_DISP: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_data_nxt = top_data;
          out_last_nxt = (disp_r == CW'(1));
          ctrl.op      = OP_ROTATE;
          disp_nxt     = disp_r - CW'(1);
          if (disp_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register valid: load wins, else clear when taken
  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  bls_chain #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .sel_idx   (sel_idx),
    .last_idx  (last_idx),
    .top_data  (top_data),
    .peek_data (peek_data)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      disp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      disp_r      <= disp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.data   = out_data_r;
  assign out_ch.last   = out_last_r;

`ifndef SYNTHESIS
  // Fill count never exceeds the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count above depth");

  // No command is taken during a display sweep
  a_disp_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP) |-> !in_ready)
    else $error("command taken during display");

  // Display leaves the fill count unchanged
  a_disp_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP) |=> $stable(cnt_r))
    else $error("fill count moved during display");

  // A successful push echoes the pushed word
  a_push_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.cmd == CMD_PUSH) && !full)
      |=> (out_valid_r && (out_data_r == $past(in_ch.value))))
    else $error("push result mismatch");
`endif

endmodule

// ----- design/bls_cell.sv -----
`timescale 1ns / 1ps

module bls_cell import bls_pkg::*; #(
  parameter int IW  = 3,
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic [IW-1:0]            sel_idx,
  input  logic [IW-1:0]            last_idx,
  input  logic signed [WORD_W-1:0] above_data,
  input  logic signed [WORD_W-1:0] below_data,
  input  logic signed [WORD_W-1:0] wrap_data,
  output logic signed [WORD_W-1:0] data_q,
  output logic signed [WORD_W-1:0] peek_data
);

  logic signed [WORD_W-1:0] data_r;
  logic signed [WORD_W-1:0] data_nxt;
  logic                     sel_hit;
  logic                     last_hit;

  assign sel_hit  = (sel_idx == IW'(IDX));
  assign last_hit = (last_idx == IW'(IDX));

  // Pick the next word from a neighbor, the top, or the new value
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      OP_PUSH:   data_nxt = above_data;
      OP_POP:    data_nxt = below_data;
      OP_ROTATE: data_nxt = last_hit ? wrap_data : below_data;
      OP_WRITE:  data_nxt = sel_hit ? ctrl.value : data_r;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q    = data_r;
  // Drive the read bus only when addressed
  assign peek_data = sel_hit ? data_r : '0;

endmodule

// ----- design/bls_chain.sv -----
`timescale 1ns / 1ps

module bls_chain import bls_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic [IW-1:0]            sel_idx,
  input  logic [IW-1:0]            last_idx,
  output logic signed [WORD_W-1:0] top_data,
  output logic signed [WORD_W-1:0] peek_data
);

  logic signed [WORD_W-1:0] cell_data [DEPTH];
  logic signed [WORD_W-1:0] cell_peek [DEPTH];

  // Row of cells, cell 0 holds the top of the stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] above;
    logic signed [WORD_W-1:0] below;

    if (i == 0) begin : g_first
      assign above = ctrl.value;
    end else begin : g_mid_a
      assign above = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign below = cell_data[i];
    end else begin : g_mid_b
      assign below = cell_data[i+1];
    end

    bls_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .sel_idx    (sel_idx),
      .last_idx   (last_idx),
      .above_data (above),
      .below_data (below),
      .wrap_data  (cell_data[0]),
      .data_q     (cell_data[i]),
      .peek_data  (cell_peek[i])
    );
  end

  // Merge the one addressed cell onto the read bus
  always_comb begin
    peek_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      peek_data = peek_data | cell_peek[i];
    end
  end

  assign top_data = cell_data[0];

endmodule
